// ----- rtl/dgs_pkg.sv -----
// ----------------------------------------------------------------------------
// dgs_pkg: shared types and constants of the diagonal Gaussian scorer
// Field widths, operation codes, register indexes and the table entry type
// that the table memory, the term multiplier and the top level share.
// ----------------------------------------------------------------------------
package dgs_pkg;

  localparam int X_W    = 16;  // feature element, signed Q8.8
  localparam int MEAN_W = 32;  // mean entry, signed Q24.8
  localparam int LOADP_W = 32; // precision value of a load, unsigned Q24.8
  localparam int PREC_W = 40;  // stored precision entry, signed Q32.8
  localparam int ACC_W  = 64;  // accumulator and score, signed Q40.24
  localparam int LOGN_W = 40;  // log normalization constant, signed Q16.24
  localparam int DIMC_W = 7;   // dimension count register
  localparam int IDX_W  = 6;   // dimension index of an item
  localparam int NUM_W  = 9;   // holds any index or count up to the largest table
  localparam int PROD_W = 104; // full product of a 64-bit square and a 40-bit magnitude

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_LOG_NORM   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_IN_USE = 2'd1;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_SCORE = 2'd1;
  localparam logic [1:0] OP_ADD   = 2'd2;
  localparam logic [1:0] OP_SUB   = 2'd3;

  typedef struct packed {
    logic signed [MEAN_W-1:0] mean;
    logic signed [PREC_W-1:0] prec;
  } entry_t;

  // Status of the term multiplier toward the sequencer.
  typedef struct packed {
    logic done;
    logic clip;
  } mul_stat_t;

endpackage

// ----- rtl/diagonal_gaussian_scorer_top.sv -----
// ----------------------------------------------------------------------------
// diagonal_gaussian_scorer_top: fixed-point diagonal Gaussian scorer
// Keeps mean and precision tables, accumulates Mahalanobis terms of a
// frame and emits the log likelihood when the last dimension arrives.
// ----------------------------------------------------------------------------
// The block takes one item per input transfer, its operation in tuser.
// A load writes a table entry in the transfer cycle and the block is ready
// again in the next cycle. An add or subtract item reads its entry, updates
// mean and precision with saturation and writes it back via the read and
// update states. A score item reads its entry, then runs the deviation square
// and the 64x40-bit product through one shared 32x32 multiplier in five
// passes, then accumulates; if it closes the frame it passes the emit state,
// staying there only while an earlier result still waits in the output
// register. The table read-modify-write, one item at a time, and the
// multiplier passes keep a new item out until the last is through. Non-load
// items addressing a dimension at or beyond the count in use are dropped in
// their transfer cycle. The score is log_norm minus half the accumulated sum
// (rounded toward minus infinity), and result tuser flags any frame clipping.
// ----------------------------------------------------------------------------
module diagonal_gaussian_scorer_top #(
  parameter int MAX_DIM = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dgs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dgs_pkg::CFG_DATA_W-1:0]     cfg_data_i,

  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [5:0] dim_index, [21:6] sample, [53:22] mean_value,
  // [85:54] precision_value, [87:86] zero
  input  logic [87:0] s_axis_tdata,
  // [1:0] op
  input  logic [1:0]  s_axis_tuser,

  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [63:0] score
  output logic [63:0] m_axis_tdata,
  // [0] saturated
  output logic [0:0]  m_axis_tuser
);
  import dgs_pkg::*;

  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  // Configuration registers.
  logic signed [LOGN_W-1:0] log_norm_q;
  logic [DIMC_W-1:0]        dim_q;

  // Sequencer and item registers.
  logic [2:0]               state_q, state_d;
  logic [1:0]               op_q;
  logic signed [X_W-1:0]    x_q;
  logic [AW-1:0]            addr_q;
  logic                     last_q;
  logic [23:0]              sq_q;

  // Frame accumulator and clip flag.
  logic signed [ACC_W-1:0]  acc_q;
  logic                     clip_q;

  // Output register.
  logic                     out_valid_q;
  logic [ACC_W-1:0]         out_score_q;
  logic                     out_sat_q;

  // Input fields.
  logic [1:0]               in_op;
  logic [IDX_W-1:0]         in_idx;
  logic signed [X_W-1:0]    in_x;
  logic signed [MEAN_W-1:0] in_mean;
  logic [LOADP_W-1:0]       in_prec;
  logic [NUM_W-1:0]         in_idx_w;
  logic [AW-1:0]            in_addr;
  logic                     in_xfer;

  logic [NUM_W-1:0]         eff_n;
  logic                     in_active;

  // Table ports.
  logic                     tbl_we;
  logic [AW-1:0]            tbl_waddr;
  entry_t                   tbl_wdata;
  logic                     tbl_re;
  entry_t                   rd_entry;

  // Arithmetic.
  logic signed [MEAN_W:0]   dev;
  logic [31:0]              dev_mag;
  logic signed [2*X_W-1:0]  x_sq;
  logic signed [MEAN_W:0]   mean_sum;
  logic signed [PREC_W:0]   prec_sum;
  logic                     mean_ovf;
  logic                     prec_ovf;
  logic signed [MEAN_W-1:0] mean_new;
  logic signed [PREC_W-1:0] prec_new;
  logic signed [ACC_W:0]    acc_sum;
  logic                     acc_ovf;
  logic signed [ACC_W-1:0]  acc_new;
  logic signed [ACC_W-1:0]  score_val;
  logic                     emit_go;

  logic                     mul_start;
  mul_stat_t                mul_stat;
  logic signed [ACC_W-1:0]  mul_term;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_norm_q <= '0;
      dim_q      <= 7'd64;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_LOG_NORM:   log_norm_q <= cfg_data_i[LOGN_W-1:0];
        CFG_DIM_IN_USE: dim_q      <= cfg_data_i[DIMC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Unpack the input transfer.
  assign in_op    = s_axis_tuser;
  assign in_idx   = s_axis_tdata[5:0];
  assign in_x     = s_axis_tdata[21:6];
  assign in_mean  = s_axis_tdata[53:22];
  assign in_prec  = s_axis_tdata[85:54];
  assign in_idx_w = {{(NUM_W-IDX_W){1'b0}}, in_idx};
  assign in_addr  = in_idx_w[AW-1:0];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // A count of zero acts as one and a count above the table depth is capped.
  always_comb begin
    if (dim_q == '0) begin
      eff_n = NUM_W'(1);
    end else if ({2'd0, dim_q} > NUM_W'(MAX_DIM)) begin
      eff_n = NUM_W'(MAX_DIM);
    end else begin
      eff_n = {2'd0, dim_q};
    end
  end

  assign in_active = (in_op != OP_LOAD) && (in_idx_w < eff_n);

  // Deviation of the sample from the mean; its magnitude fits 32 bits.
  assign dev     = $signed({{(MEAN_W-X_W+1){x_q[X_W-1]}}, x_q})
                 - $signed({rd_entry.mean[MEAN_W-1], rd_entry.mean});
  assign dev_mag = dev[MEAN_W] ? 32'(-dev) : dev[31:0];
  assign x_sq    = x_q * x_q;

  // Statistic update with saturation to the entry widths.
  always_comb begin
    if (op_q == OP_SUB) begin
      mean_sum = $signed({rd_entry.mean[MEAN_W-1], rd_entry.mean})
               - $signed({{(MEAN_W-X_W+1){x_q[X_W-1]}}, x_q});
      prec_sum = $signed({rd_entry.prec[PREC_W-1], rd_entry.prec})
               - $signed({17'd0, sq_q});
    end else begin
      mean_sum = $signed({rd_entry.mean[MEAN_W-1], rd_entry.mean})
               + $signed({{(MEAN_W-X_W+1){x_q[X_W-1]}}, x_q});
      prec_sum = $signed({rd_entry.prec[PREC_W-1], rd_entry.prec})
               + $signed({17'd0, sq_q});
    end
  end

  assign mean_ovf = mean_sum[MEAN_W] != mean_sum[MEAN_W-1];
  assign prec_ovf = prec_sum[PREC_W] != prec_sum[PREC_W-1];
  assign mean_new = mean_ovf ? {mean_sum[MEAN_W], {(MEAN_W-1){~mean_sum[MEAN_W]}}}
                             : mean_sum[MEAN_W-1:0];
  assign prec_new = prec_ovf ? {prec_sum[PREC_W], {(PREC_W-1){~prec_sum[PREC_W]}}}
                             : prec_sum[PREC_W-1:0];

  // Saturating accumulation of the finished term.
  assign acc_sum = $signed({acc_q[ACC_W-1], acc_q}) + $signed({mul_term[ACC_W-1], mul_term});
  assign acc_ovf = acc_sum[ACC_W] != acc_sum[ACC_W-1];
  assign acc_new = acc_ovf ? {acc_sum[ACC_W], {(ACC_W-1){~acc_sum[ACC_W]}}}
                           : acc_sum[ACC_W-1:0];

  // Half the sum, rounded down, is an arithmetic shift.
  assign score_val = $signed({{(ACC_W-LOGN_W){log_norm_q[LOGN_W-1]}}, log_norm_q})
                   - (acc_q >>> 1);

  // The result may enter the output register once the previous one has left.
  assign emit_go = !out_valid_q || m_axis_tready;

  // Table access: loads write in the transfer cycle, updates write back.
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = addr_q;
    tbl_wdata = '{mean: mean_new, prec: prec_new};
    if (state_q == ST_UPD) begin
      tbl_we = 1'b1;
    end else if (in_xfer && in_op == OP_LOAD && in_idx_w < NUM_W'(MAX_DIM)) begin
      tbl_we    = 1'b1;
      tbl_waddr = in_addr;
      tbl_wdata = '{mean: in_mean, prec: {{(PREC_W-LOADP_W){1'b0}}, in_prec}};
    end
  end

  assign tbl_re    = in_xfer && in_active;
  assign mul_start = (state_q == ST_READ) && (op_q == OP_SCORE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (tbl_re) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = (op_q == OP_SCORE) ? ST_MUL : ST_UPD;
      ST_UPD:  state_d = ST_IDLE;
      ST_MUL: begin
        if (mul_stat.done) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC:  state_d = last_q ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (emit_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // A new result enters as the previous one leaves or once it has left.
      if (state_q == ST_EMIT && emit_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_UPD: begin
          if (mean_ovf || prec_ovf) begin
            clip_q <= 1'b1;
          end
        end
        ST_ACC: begin
          acc_q <= acc_new;
          if (acc_ovf || mul_stat.clip) begin
            clip_q <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            acc_q       <= '0;
            clip_q      <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q   <= in_op;
      x_q    <= in_x;
      addr_q <= in_addr;
      last_q <= in_idx_w == (eff_n - NUM_W'(1));
    end
    if (state_q == ST_READ) begin
      sq_q <= x_sq[31:8];
    end
    if (state_q == ST_EMIT && emit_go) begin
      out_score_q <= score_val;
      out_sat_q   <= clip_q;
    end
  end

  dgs_table #(
    .DEPTH (MAX_DIM)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (in_addr),
    .rdata_o (rd_entry)
  );

  dgs_term_mul u_term_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .dev_mag_i (dev_mag),
    .prec_i    (rd_entry.prec),
    .stat_o    (mul_stat),
    .term_o    (mul_term)
  );

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_score_q;
  assign m_axis_tuser[0] = out_sat_q;

  // The table is written only by a load transfer or by the write-back step.
  a_write_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |-> (state_q == ST_IDLE || state_q == ST_UPD))
    else $error("table written outside a load or write-back");

  // A finished term only shows up while the sequencer waits for it.
  a_mul_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_stat.done |-> state_q == ST_MUL)
    else $error("multiplier finished while not awaited");

  // Emitting a frame clears the accumulator and the clip flag.
  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && emit_go) |=> (acc_q == '0 && !clip_q && out_valid_q))
    else $error("frame state not cleared after emission");

  // A load never starts a multi-cycle sequence.
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_op == OP_LOAD) |=> state_q == ST_IDLE)
    else $error("load left the sequencer busy");

endmodule

// ----- rtl/dgs_table.sv -----
// ----------------------------------------------------------------------------
// dgs_table: mean and precision table
// One synchronous memory with one write port and one read port; read data
// is registered and appears in the cycle after the read strobe.
// ----------------------------------------------------------------------------
module dgs_table #(
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  dgs_pkg::entry_t wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output dgs_pkg::entry_t rdata_o
);
  import dgs_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/dgs_term_mul.sv -----
// ----------------------------------------------------------------------------
// dgs_term_mul: iterative score term multiplier
// Squares the deviation magnitude and multiplies it by the precision
// magnitude with one shared 32x32 multiplier over five passes, then
// saturates and applies the precision sign.
// ----------------------------------------------------------------------------
module dgs_term_mul (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [31:0]                      dev_mag_i,
  input  logic signed [dgs_pkg::PREC_W-1:0] prec_i,
  output dgs_pkg::mul_stat_t               stat_o,
  output logic signed [dgs_pkg::ACC_W-1:0] term_o
);
  import dgs_pkg::*;

  localparam logic [2:0] LAST_STEP = 3'd6;

  logic               busy_q;
  logic [2:0]         step_q;
  logic [31:0]        ad_q;
  logic               neg_q;
  logic [PREC_W-1:0]  ap_q;
  logic [63:0]        d2_q;
  logic [63:0]        pp_q;
  logic               pp_v_q;
  logic [1:0]         sh_q;
  logic [PROD_W-1:0]  prod_q;
  logic               done_q;
  logic               clip_q;
  logic signed [ACC_W-1:0] term_q;

  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [1:0]         sh_d;
  logic [63:0]        mul_p;
  logic [PROD_W-1:0]  pp_shifted;
  logic [PROD_W-1:0]  lim;
  logic               ovf;
  logic [63:0]        mag;
  logic [PREC_W-1:0]  ap_in;

  assign ap_in = prec_i[PREC_W-1] ? (~prec_i + 1'b1) : prec_i;

  // Step 0 squares the deviation; steps 1 to 4 form the partial products.
  always_comb begin
    mul_a = ad_q;
    mul_b = ad_q;
    sh_d  = 2'd0;
    case (step_q)
      3'd1: begin
        mul_a = d2_q[31:0];
        mul_b = ap_q[31:0];
        sh_d  = 2'd0;
      end
      3'd2: begin
        mul_a = d2_q[63:32];
        mul_b = ap_q[31:0];
        sh_d  = 2'd1;
      end
      3'd3: begin
        mul_a = d2_q[31:0];
        mul_b = {24'd0, ap_q[PREC_W-1:32]};
        sh_d  = 2'd1;
      end
      3'd4: begin
        mul_a = d2_q[63:32];
        mul_b = {24'd0, ap_q[PREC_W-1:32]};
        sh_d  = 2'd2;
      end
      default: begin
        mul_a = ad_q;
        mul_b = ad_q;
        sh_d  = 2'd0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    case (sh_q)
      2'd1:    pp_shifted = {8'd0, pp_q, 32'd0};
      2'd2:    pp_shifted = {pp_q[39:0], 64'd0};
      default: pp_shifted = {40'd0, pp_q};
    endcase
  end

  // A negative precision may reach one step further down.
  assign lim = neg_q ? {40'd0, 1'b1, 63'd0} : {41'd0, {63{1'b1}}};
  assign ovf = prod_q > lim;
  assign mag = ovf ? lim[63:0] : prod_q[63:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 3'd0;
      pp_v_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 3'd0;
        pp_v_q <= 1'b0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q >= 3'd1 && step_q <= 3'd4) begin
          pp_v_q <= 1'b1;
        end else begin
          pp_v_q <= 1'b0;
        end
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ad_q   <= dev_mag_i;
      neg_q  <= prec_i[PREC_W-1];
      ap_q   <= ap_in;
      prod_q <= '0;
    end else if (busy_q) begin
      if (step_q == 3'd0) begin
        d2_q <= mul_p;
      end
      pp_q <= mul_p;
      sh_q <= sh_d;
      if (pp_v_q) begin
        prod_q <= prod_q + pp_shifted;
      end
      if (step_q == LAST_STEP) begin
        clip_q <= ovf;
        term_q <= neg_q ? $signed(~mag + 64'd1) : $signed(mag);
      end
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.clip = clip_q;
  assign term_o      = term_q;

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the diagonal Gaussian scorer
// Loads mean and precision entries, streams score, add and subtract items
// under random idling on both stream sides, and compares every frame score
// and clip flag with a scoreboard that predicts the fixed-point arithmetic.
// ----------------------------------------------------------------------------
module tb_top;
  import dgs_pkg::*;

  localparam int TABLE_DEPTH   = 64;
  localparam int SETTLE_CYCLES = 20;

  localparam logic signed [LOGN_W-1:0] LN_MAX = {1'b0, {(LOGN_W-1){1'b1}}};
  localparam logic signed [LOGN_W-1:0] LN_MIN = {1'b1, {(LOGN_W-1){1'b0}}};
  localparam logic [MEAN_W-1:0]        MEAN_HI = 32'h7FFF_FFFF;
  localparam logic [MEAN_W-1:0]        MEAN_LO = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]               op;
    logic [IDX_W-1:0]         idx;
    logic signed [X_W-1:0]    sample;
    logic signed [MEAN_W-1:0] mean_v;
    logic [LOADP_W-1:0]       prec_v;
  } gauss_item_t;

  typedef struct packed {
    logic [ACC_W-1:0] score;
    logic             sat;
  } frame_score_t;

  // Tracks the Gaussian tables and the running Mahalanobis sum, and holds
  // the frame scores that the block still owes.
  class frame_scoreboard;
    logic signed [MEAN_W-1:0] mean_tab [TABLE_DEPTH];
    logic signed [PREC_W-1:0] prec_tab [TABLE_DEPTH];
    logic signed [ACC_W-1:0]  acc;
    logic                     clip;
    logic signed [LOGN_W-1:0] log_norm;
    logic [DIMC_W-1:0]        dim_cnt;
    frame_score_t             expected_q[$];
    int                       mismatches;

    function new();
      acc        = '0;
      clip       = 1'b0;
      log_norm   = '0;
      dim_cnt    = DIMC_W'(TABLE_DEPTH);
      mismatches = 0;
    endfunction

    function int active_dims();
      if (dim_cnt == '0) return 1;
      if (int'(dim_cnt) > TABLE_DEPTH) return TABLE_DEPTH;
      return int'(dim_cnt);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      if (index == CFG_LOG_NORM) log_norm = data[LOGN_W-1:0];
      else if (index == CFG_DIM_IN_USE) dim_cnt = data[DIMC_W-1:0];
    endfunction

    // Clips to a signed range of w bits; any clip sticks until the frame ends.
    function logic signed [127:0] saturate(logic signed [127:0] v, int w);
      logic signed [127:0] hi;
      logic signed [127:0] lo;
      hi = (128'sd1 <<< (w - 1)) - 128'sd1;
      lo = -hi - 128'sd1;
      if (v > hi) begin
        clip = 1'b1;
        return hi;
      end
      if (v < lo) begin
        clip = 1'b1;
        return lo;
      end
      return v;
    endfunction

    function void note_item(gauss_item_t it);
      logic signed [127:0] x;
      logic signed [127:0] d;
      logic signed [127:0] m;
      logic signed [127:0] p;
      logic signed [127:0] r;
      frame_score_t        e;
      int                  n;
      n = active_dims();
      if (it.op == OP_LOAD) begin
        mean_tab[it.idx] = it.mean_v;
        prec_tab[it.idx] = {8'd0, it.prec_v};
        return;
      end
      if (int'(it.idx) >= n) return;
      x = 128'($signed(it.sample));
      m = 128'($signed(mean_tab[it.idx]));
      p = 128'($signed(prec_tab[it.idx]));
      if (it.op == OP_SCORE) begin
        d   = x - m;
        r   = saturate(d * d * p, ACC_W);
        r   = saturate(128'($signed(acc)) + r, ACC_W);
        acc = r[ACC_W-1:0];
        if (int'(it.idx) == n - 1) begin
          // The halving shift rounds toward minus infinity.
          r       = 128'($signed(log_norm)) - (128'($signed(acc)) >>> 1);
          e.score = r[ACC_W-1:0];
          e.sat   = clip;
          expected_q.push_back(e);
          acc  = '0;
          clip = 1'b0;
        end
      end else begin
        d = (x * x) >>> 8;
        if (it.op == OP_ADD) begin
          m = m + x;
          p = p + d;
        end else begin
          m = m - x;
          p = p - d;
        end
        r = saturate(m, MEAN_W);
        mean_tab[it.idx] = r[MEAN_W-1:0];
        r = saturate(p, PREC_W);
        prec_tab[it.idx] = r[PREC_W-1:0];
      end
    endfunction

    function void flag(string what, logic [ACC_W-1:0] exp_v, logic [ACC_W-1:0] act_v);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %0d: %s expected %h got %h", mismatches, what, exp_v, act_v);
    endfunction

    function void check_result(logic [ACC_W-1:0] score, logic sat);
      frame_score_t e;
      if (expected_q.size() == 0) begin
        flag("score with none outstanding", '0, score);
        return;
      end
      e = expected_q.pop_front();
      if (score !== e.score) flag("score", e.score, score);
      if (sat !== e.sat) flag("saturated", ACC_W'(e.sat), ACC_W'(sat));
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [87:0]           s_axis_tdata  = '0;
  logic [1:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [63:0]           m_axis_tdata;
  logic [0:0]            m_axis_tuser;

  frame_scoreboard sb = new();
  bit              quiet = 1'b0;            // no idling on either side while set
  bit              loaded [TABLE_DEPTH];    // entries written by a load so far
  int              taken = 0;               // items that the block acts on

  diagonal_gaussian_scorer_top #(
    .MAX_DIM(TABLE_DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #4 clk_i = ~clk_i;
  end

  function automatic bit idle_now();
    return !quiet && ($urandom_range(99) < 6);
  endfunction

  // Result side: check each transfer, then pick the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser[0]);
    m_axis_tready <= !idle_now();
  end

  function automatic gauss_item_t mk(logic [1:0] op, int idx, int sample, logic [31:0] mean_v,
                                     logic [31:0] prec_v);
    gauss_item_t it;
    it.op     = op;
    it.idx    = IDX_W'(idx);
    it.sample = X_W'(sample);
    it.mean_v = mean_v;
    it.prec_v = prec_v;
    return it;
  endfunction

  // Mostly small entries so that frame sums stay in range, some wide or
  // extreme ones so that terms clip.
  function automatic gauss_item_t rand_load(int idx);
    logic [31:0] m;
    logic [31:0] p;
    case ($urandom_range(5))
      0: begin
        m = $urandom;
        p = $urandom;
      end
      1: begin
        m = $urandom_range(1) ? MEAN_HI : MEAN_LO;
        p = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      end
      default: begin
        m = 32'(int'($urandom_range(131071)) - 65536);
        p = $urandom_range(4096);
      end
    endcase
    return mk(OP_LOAD, idx, int'($urandom), m, p);
  endfunction

  function automatic logic signed [LOGN_W-1:0] rand_ln();
    return LOGN_W'({$urandom, $urandom});
  endfunction

  task automatic send_item(gauss_item_t it);
    while (idle_now()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, it.prec_v, it.mean_v, it.sample, it.idx};
    s_axis_tuser  <= it.op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (it.op == OP_LOAD || int'(it.idx) < sb.active_dims()) taken++;
    if (it.op == OP_LOAD) loaded[it.idx] = 1'b1;
    sb.note_item(it);
  endtask

  task automatic ensure_loaded(int idx);
    if (!loaded[idx]) send_item(rand_load(idx));
  endtask

  // Waits until every frame score has arrived, then lets the block finish
  // any item that produces no result.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(index, data);
  endtask

  task automatic configure(logic signed [LOGN_W-1:0] ln, logic [DIMC_W-1:0] dims);
    settle();
    write_reg(CFG_LOG_NORM, ln);
    write_reg(CFG_DIM_IN_USE, CFG_DATA_W'(dims));
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly whole frames with random samples, plus loads, table updates and
  // free-form noise that may break frames or hit unused dimensions.
  task automatic random_phase(int quota);
    int          target;
    int          n;
    int          k;
    int          j;
    int          t;
    int          cut;
    int          order[$];
    gauss_item_t it;
    target = taken + quota;
    n      = sb.active_dims();
    while (taken < target) begin
      k = $urandom_range(99);
      if (k < 70) begin
        order.delete();
        for (int i = 0; i < n; i++) begin
          ensure_loaded(i);
          order.push_back(i);
        end
        if ($urandom_range(4) == 0) begin
          for (int i = n - 1; i > 0; i--) begin
            j        = $urandom_range(i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
          end
        end
        cut = ($urandom_range(9) == 0) ? $urandom_range(n) : n;
        for (int i = 0; i < cut; i++)
          send_item(mk(OP_SCORE, order[i], int'($urandom), $urandom, $urandom));
      end else if (k < 80) begin
        send_item(rand_load($urandom_range(TABLE_DEPTH - 1)));
      end else if (k < 90) begin
        j = $urandom_range(n - 1);
        ensure_loaded(j);
        send_item(mk($urandom_range(1) ? OP_ADD : OP_SUB, j, int'($urandom), $urandom,
                     $urandom));
      end else begin
        it = mk(2'($urandom_range(3)), $urandom_range(TABLE_DEPTH - 1), int'($urandom),
                $urandom, $urandom);
        if (it.op != OP_LOAD && int'(it.idx) < n) ensure_loaded(int'(it.idx));
        send_item(it);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Four dimensions in use: extreme entries, a clipping term, an item past
    // the dimensions in use, a whole frame and frames without the lower dimensions.
    configure(LN_MAX, 7'd4);
    send_item(mk(OP_LOAD, 0, 0, MEAN_HI, 32'hFFFF_FFFF));
    send_item(mk(OP_LOAD, 1, 0, MEAN_LO, 32'h0));
    send_item(mk(OP_LOAD, 2, 0, 32'h0, 32'd256));
    send_item(mk(OP_LOAD, 3, 0, 32'd100, 32'd1));
    send_item(mk(OP_SCORE, 0, -32768, '0, '0));
    send_item(mk(OP_SCORE, 9, 77, '1, '1));
    send_item(mk(OP_SCORE, 1, 32767, '0, '0));
    send_item(mk(OP_SCORE, 2, 0, '0, '0));
    send_item(mk(OP_SCORE, 3, 5, '0, '0));
    send_item(mk(OP_SCORE, 2, 256, '0, '0));
    send_item(mk(OP_SCORE, 3, -7, '0, '0));
    // Subtracting a large square drives precision negative.
    send_item(mk(OP_SUB, 2, -32768, '0, '0));
    send_item(mk(OP_SCORE, 2, 100, '0, '0));
    send_item(mk(OP_SCORE, 3, 0, '0, '0));
    // Mean updates that clip at both ends, flagged in the next score.
    send_item(mk(OP_ADD, 0, 32767, '0, '0));
    send_item(mk(OP_SUB, 1, 1, '0, '0));
    send_item(mk(OP_SCORE, 3, 0, '0, '0));
    send_item(mk(OP_LOAD, 63, 32767, MEAN_LO, 32'hFFFF_FFFF));
    send_item(mk(OP_ADD, 63, 1, '0, '0));

    // A zero dimension count acts as one: every score item for dimension 0 closes a frame.
    configure(LN_MIN, 7'd0);
    send_item(mk(OP_LOAD, 0, 0, 32'h0, 32'd256));
    send_item(mk(OP_SCORE, 0, -32768, '0, '0));
    send_item(mk(OP_SCORE, 5, 1, '0, '0));
    send_item(mk(OP_SCORE, 0, 32767, '0, '0));

    configure(rand_ln(), 7'd64);
    random_phase(300);
    configure(LN_MIN, 7'd1);
    random_phase(150);
    quiet <= 1'b1;
    configure(rand_ln(), 7'd127);
    random_phase(250);
    quiet <= 1'b0;
    configure('0, 7'd5);
    random_phase(200);
    configure(rand_ln(), 7'($urandom_range(2, 63)));
    random_phase(200);
    configure(LN_MAX, 7'd0);
    random_phase(100);
    configure(rand_ln(), 7'd16);
    random_phase(230);

    settle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
